@@ hdl/tcp_option_kind_walker_assert.svh @@
// Assertion macros for the TCP option kind walker.
// Expects clk and rst_n in scope at the point of use.
`ifndef TCP_OPTION_KIND_WALKER_ASSERT_SVH
`define TCP_OPTION_KIND_WALKER_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define TCPW_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tcpw same-cycle check failed");

// Consequent must hold in the cycle after the antecedent.
`define TCPW_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tcpw next-cycle check failed");

`endif

@@ hdl/tcpw_pkg.sv @@
// Shared types and constants for the TCP option kind walker.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package tcpw_pkg;

    typedef enum logic [1:0] {
        PH_IDLE  = 2'd0,
        PH_FIXED = 2'd1,
        PH_OPT   = 2'd2,
        PH_LEN   = 2'd3
    } parse_phase_t;

    typedef enum logic [1:0] {
        REC_FLAGS  = 2'd0,
        REC_OPTION = 2'd1,
        REC_END    = 2'd2
    } rec_kind_t;

    // One queue entry: a record, optionally followed by an end record.
    typedef struct packed {
        rec_kind_t   kind;
        logic [5:0]  flags;
        logic [7:0]  opt;
        logic        trail_end;
    } rec_entry_t;

    localparam int QUEUE_DEPTH = 4;

    localparam logic [5:0] POS_MAX     = 6'd63;
    localparam logic [5:0] POS_OFFSET  = 6'd12;
    localparam logic [5:0] POS_FLAGS   = 6'd13;
    localparam logic [5:0] POS_LAST    = 6'd19;
    localparam logic [3:0] WORDS_BASIC = 4'd5;
    localparam logic [5:0] FIXED_BYTES = 6'd20;

endpackage

`default_nettype wire

@@ hdl/tcpw_front.sv @@
// Front end: accepts header bytes, tracks the header walk and classifies each
// byte into at most one queue entry. Depends on tcpw_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tcpw_front
    import tcpw_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_ready,
    input  wire logic [7:0] header_byte,
    input  wire logic       segment_start,
    input  wire logic       q_full,
    output logic            q_push,
    output rec_entry_t      q_data
);

    parse_phase_t phase_reg, phase_next, phase_eff;
    logic [5:0]   pos_reg, pos_next;
    logic [3:0]   hw_reg, hw_next, hw_eff;
    logic [5:0]   rem_reg, rem_next, rem_eff, rem_dec;
    logic [7:0]   skip_reg, skip_next, skip_eff;
    logic         accept;
    logic         fin;
    logic         emit_flags;
    logic         emit_opt;
    logic         single_kind;
    logic         bad_len;
    logic         to_len;

    // A start byte acts on a freshly cleared walk.
    assign phase_eff   = segment_start ? PH_FIXED : phase_reg;
    assign hw_eff      = segment_start ? 4'd0 : hw_reg;
    assign rem_eff     = segment_start ? 6'd0 : rem_reg;
    assign skip_eff    = segment_start ? 8'd0 : skip_reg;
    assign rem_dec     = rem_eff - 6'd1;
    assign single_kind = (header_byte < 8'd2);
    assign bad_len     = single_kind || (header_byte > ({2'b00, rem_eff} + 8'd1));
    assign to_len      = (skip_eff == 8'd0) && !single_kind && (rem_eff >= 6'd2);

    assign in_ready = !q_full;
    assign accept   = in_valid && in_ready;
    assign q_push   = accept && (fin || emit_flags || emit_opt);

    // Counters, record decisions.
    always_comb
    begin
        pos_next   = pos_reg;
        hw_next    = hw_reg;
        rem_next   = rem_reg;
        skip_next  = skip_reg;
        fin        = 1'b0;
        emit_flags = 1'b0;
        emit_opt   = 1'b0;
        if (segment_start)
        begin
            pos_next  = 6'd0;
            hw_next   = 4'd0;
            rem_next  = 6'd0;
            skip_next = 8'd0;
        end
        else if (phase_reg != PH_IDLE && pos_reg != POS_MAX)
        begin
            pos_next = pos_reg + 6'd1;
        end
        unique case (phase_eff)
            PH_FIXED:
            begin
                if (pos_next == POS_OFFSET)
                begin
                    hw_next = header_byte[7:4];
                end
                else if (pos_next == POS_FLAGS)
                begin
                    emit_flags = 1'b1;
                end
                else if (pos_next == POS_LAST)
                begin
                    if (hw_eff <= WORDS_BASIC)
                    begin
                        fin = 1'b1;
                    end
                    else
                    begin
                        rem_next  = {hw_eff, 2'b00} - FIXED_BYTES;
                        skip_next = 8'd0;
                    end
                end
            end
            PH_OPT:
            begin
                if (skip_eff != 8'd0)
                begin
                    skip_next = skip_eff - 8'd1;
                    rem_next  = rem_dec;
                    fin       = (rem_dec == 6'd0);
                end
                else
                begin
                    emit_opt = 1'b1;
                    if (single_kind)
                    begin
                        rem_next = rem_dec;
                        fin      = (rem_dec == 6'd0);
                    end
                    else if (rem_eff < 6'd2)
                    begin
                        fin = 1'b1;
                    end
                    else
                    begin
                        rem_next = rem_dec;
                    end
                end
            end
            PH_LEN:
            begin
                if (bad_len)
                begin
                    fin = 1'b1;
                end
                else
                begin
                    rem_next  = rem_dec;
                    skip_next = header_byte - 8'd2;
                    fin       = (rem_dec == 6'd0);
                end
            end
            PH_IDLE:
            begin
            end
        endcase
    end

    // Walk phase.
    always_comb
    begin
        phase_next = phase_eff;
        if (fin)
        begin
            phase_next = PH_IDLE;
        end
        else
        begin
            unique case (phase_eff)
                PH_FIXED: phase_next = (pos_next == POS_LAST) ? PH_OPT : PH_FIXED;
                PH_OPT:   phase_next = to_len ? PH_LEN : PH_OPT;
                PH_LEN:   phase_next = PH_OPT;
                PH_IDLE:  phase_next = PH_IDLE;
            endcase
        end
    end

    // Queue entry. An option record that also ends the walk carries a trailing end.
    always_comb
    begin
        q_data.kind      = REC_END;
        q_data.flags     = 6'd0;
        q_data.opt       = 8'd0;
        q_data.trail_end = 1'b0;
        if (emit_flags)
        begin
            q_data.kind  = REC_FLAGS;
            q_data.flags = header_byte[5:0];
        end
        else if (emit_opt)
        begin
            q_data.kind      = REC_OPTION;
            q_data.opt       = header_byte;
            q_data.trail_end = fin;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            pos_reg   <= 6'd0;
            hw_reg    <= 4'd0;
            rem_reg   <= 6'd0;
            skip_reg  <= 8'd0;
        end
        else if (accept)
        begin
            phase_reg <= phase_next;
            pos_reg   <= pos_next;
            hw_reg    <= hw_next;
            rem_reg   <= rem_next;
            skip_reg  <= skip_next;
        end
    end

endmodule

`default_nettype wire

@@ hdl/tcpw_queue.sv @@
// Small FIFO of record entries between the front and back ends.
// Depends on tcpw_pkg for the entry type.
`timescale 1ns / 1ps
`default_nettype none

module tcpw_queue
    import tcpw_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH
)
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       push,
    input  wire rec_entry_t push_data,
    input  wire logic       pop,
    output rec_entry_t      pop_data,
    output logic            full,
    output logic            empty
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    rec_entry_t    mem_reg [DEPTH];
    logic [AW-1:0] wr_reg, wr_next;
    logic [AW-1:0] rd_reg, rd_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          do_push;
    logic          do_pop;

    assign full     = (cnt_reg == FULL_CNT);
    assign empty    = (cnt_reg == '0);
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign pop_data = mem_reg[rd_reg];

    always_comb
    begin
        wr_next  = do_push ? ((wr_reg == LAST_IDX) ? '0 : wr_reg + 1'b1) : wr_reg;
        rd_next  = do_pop ? ((rd_reg == LAST_IDX) ? '0 : rd_reg + 1'b1) : rd_reg;
        cnt_next = cnt_reg;
        if (do_push && !do_pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

endmodule

`default_nettype wire

@@ hdl/tcpw_back.sv @@
// Back end (uses tcpw_pkg): drains queue entries into the output register at one
// record per cycle unless stalled; a trailing-end entry splits into two records.
`timescale 1ns / 1ps
`default_nettype none

module tcpw_back
    import tcpw_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       q_empty,
    input  wire rec_entry_t q_data,
    output logic            q_pop,
    output logic            out_valid,
    input  wire logic       out_ready,
    output logic [1:0]      record_kind,
    output logic [5:0]      control_flags,
    output logic [7:0]      option_kind,
    output logic            last_of_run,
    output logic            pend_end
);

    logic       valid_reg, valid_next;
    logic       pend_reg, pend_next;
    rec_kind_t  kind_reg, kind_next;
    logic [5:0] flags_reg, flags_next;
    logic [7:0] opt_reg, opt_next;
    logic       last_reg, last_next;
    logic       load;

    assign load  = !valid_reg || out_ready;
    assign q_pop = load && !pend_reg && !q_empty;

    always_comb
    begin
        valid_next = valid_reg;
        pend_next  = pend_reg;
        kind_next  = kind_reg;
        flags_next = flags_reg;
        opt_next   = opt_reg;
        last_next  = last_reg;
        if (load)
        begin
            if (pend_reg)
            begin
                valid_next = 1'b1;
                pend_next  = 1'b0;
                kind_next  = REC_END;
                flags_next = 6'd0;
                opt_next   = 8'd0;
                last_next  = 1'b1;
            end
            else if (!q_empty)
            begin
                valid_next = 1'b1;
                pend_next  = q_data.trail_end;
                kind_next  = q_data.kind;
                flags_next = q_data.flags;
                opt_next   = q_data.opt;
                last_next  = !q_data.trail_end;
            end
            else
            begin
                valid_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            pend_reg  <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            pend_reg  <= pend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg  <= kind_next;
        flags_reg <= flags_next;
        opt_reg   <= opt_next;
        last_reg  <= last_next;
    end

    assign out_valid     = valid_reg;
    assign record_kind   = kind_reg;
    assign control_flags = flags_reg;
    assign option_kind   = opt_reg;
    assign last_of_run   = last_reg;
    assign pend_end      = pend_reg;

endmodule

`default_nettype wire

@@ hdl/tcp_option_kind_walker.sv @@
// Top level of the TCP option kind walker: front end, record queue, back end.
// Depends on tcpw_pkg, tcpw_front, tcpw_queue, tcpw_back and the assert header.
//
//   channel | handshake            | payload
//   --------+----------------------+-------------------------------------------
//   input   | in_valid / in_ready  | header_byte, segment_start
//   output  | out_valid / out_ready| record_kind, control_flags, option_kind,
//           |                      | last_of_run
//
// One header byte is accepted per cycle while the record queue has room.
// Each byte yields zero, one or two records, and the output register shows
// one record per cycle while out_ready allows; a record passes from the
// record queue into the output register before it reaches the output ports.
// in_ready drops only when the queue (DEPTH entries) is full.
// Reset clears the walk to idle and empties the queue and output register.
`timescale 1ns / 1ps
`default_nettype none

`include "tcp_option_kind_walker_assert.svh"

module tcp_option_kind_walker
    import tcpw_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH
)
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_ready,
    input  wire logic [7:0] header_byte,
    input  wire logic       segment_start,
    output logic            out_valid,
    input  wire logic       out_ready,
    output logic [1:0]      record_kind,
    output logic [5:0]      control_flags,
    output logic [7:0]      option_kind,
    output logic            last_of_run
);

    rec_entry_t q_in;
    rec_entry_t q_out;
    logic       q_push;
    logic       q_pop;
    logic       q_full;
    logic       q_empty;
    logic       pend_end;

    tcpw_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .header_byte   (header_byte),
        .segment_start (segment_start),
        .q_full        (q_full),
        .q_push        (q_push),
        .q_data        (q_in)
    );

    tcpw_queue #(
        .DEPTH (DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_in),
        .pop       (q_pop),
        .pop_data  (q_out),
        .full      (q_full),
        .empty     (q_empty)
    );

    tcpw_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .q_empty       (q_empty),
        .q_data        (q_out),
        .q_pop         (q_pop),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .record_kind   (record_kind),
        .control_flags (control_flags),
        .option_kind   (option_kind),
        .last_of_run   (last_of_run),
        .pend_end      (pend_end)
    );

    // Only an option record can be followed by a second record from the same byte.
    `TCPW_ASSERT_NOW(a_split_is_option, out_valid && !last_of_run, record_kind == REC_OPTION)
    // The record after a non-final one is the end record, shown at once.
    `TCPW_ASSERT_NEXT(a_end_follows, out_valid && out_ready && !last_of_run,
        out_valid && record_kind == REC_END && last_of_run)
    // The front never pushes into a full queue.
    `TCPW_ASSERT_NOW(a_no_overflow, q_push, !q_full)
    // A pending end record keeps the output register occupied.
    `TCPW_ASSERT_NOW(a_pend_has_out, pend_end, out_valid && !last_of_run)

endmodule

`default_nettype wire
